// ===== rtl/core/lss_pkg.sv =====
// Package for the LIFO stack with search: sizes, request and status codes,
// entry and memory-port structs, cost-key width helpers.
// No dependencies.
`timescale 1ns / 1ps

package lss_pkg;

	// Sizes
	localparam int DEPTH      = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int COST_WIDTH = 16;
	localparam int IN_COST_W  = 16;
	localparam int HANDLE_W   = 16;
	localparam int FILL_W     = 7;
	localparam int REQ_W      = 2;
	localparam int STATUS_W   = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [COST_WIDTH-1:0] cost;
		logic                  boat_left;
		logic [HANDLE_W-1:0]   handle;
	} entry_t;

	// Memory port commands from the sequencer
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	// Result of one request, before the fill count is attached
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 found;
		logic [IN_COST_W-1:0] cost;
		logic                 boat_left;
		logic [HANDLE_W-1:0]  handle;
	} res_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic [CNT_W-1:0] count;
	} seq_stat_t;

	// Keep the low COST_WIDTH bits of an input cost key
	function automatic logic [COST_WIDTH-1:0] narrow_cost(input logic [IN_COST_W-1:0] v);
		logic [31:0] tmp;
		tmp = 32'(v);
		return tmp[COST_WIDTH-1:0];
	endfunction

	// Zero-extend or trim a stored cost key to the output width
	function automatic logic [IN_COST_W-1:0] widen_cost(input logic [COST_WIDTH-1:0] c);
		logic [31:0] tmp;
		tmp = 32'(c);
		return tmp[IN_COST_W-1:0];
	endfunction

endpackage

// ===== rtl/core/lss_if.sv =====
// Request and response channel interfaces for the LIFO stack with search.
// Depends on lss_pkg.
`timescale 1ns / 1ps

interface lss_req_if;
	import lss_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [IN_COST_W-1:0] entry_cost;
	logic                 entry_boat_left;
	logic [HANDLE_W-1:0]  entry_handle;

	modport source (
		output valid, req_type, entry_cost, entry_boat_left, entry_handle,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_cost, entry_boat_left, entry_handle,
		output ready
	);
endinterface

interface lss_rsp_if;
	import lss_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic                 found;
	logic [IN_COST_W-1:0] out_cost;
	logic                 out_boat_left;
	logic [HANDLE_W-1:0]  out_handle;
	logic                 is_empty;
	logic [FILL_W-1:0]    fill_count;

	modport source (
		output valid, status, found, out_cost, out_boat_left, out_handle,
		       is_empty, fill_count,
		input  ready
	);
	modport sink (
		input  valid, status, found, out_cost, out_boat_left, out_handle,
		       is_empty, fill_count,
		output ready
	);
endinterface

// ===== rtl/core/lss_mem.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on lss_pkg. Contents are not reset.
`timescale 1ns / 1ps

module lss_mem (
	input  logic              clk,
	input  lss_pkg::mem_req_t mem_req,
	output lss_pkg::entry_t   rd_data
);
	import lss_pkg::*;

	entry_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data <= mem_q[mem_req.rd_addr];
		end
	end

endmodule

// ===== rtl/core/lss_seq.sv =====
// Request sequencer: keeps the fill count, drives the entry store, walks it
// for searches and holds the response register. Depends on lss_pkg, lss_if.
`timescale 1ns / 1ps

module lss_seq (
	input  logic               clk,
	input  logic               arst_n,
	lss_req_if.sink            req,
	lss_rsp_if.source          rsp,
	output lss_pkg::mem_req_t  mem_req,
	input  lss_pkg::entry_t    rd_data,
	output lss_pkg::seq_stat_t stat
);
	import lss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [COST_WIDTH-1:0] key_cost_q;
	logic                  key_boat_q;
	res_t                  res_q;
	res_t                  out_q;
	logic [FILL_W-1:0]     out_fill_q;
	logic                  out_empty_q;
	logic                  out_valid_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             match;
	logic             scan_last;
	logic             out_load;
	logic [CNT_W-1:0] cnt_dec;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign cnt_dec   = count_q - CNT_W'(1);
	assign match     = (rd_data.cost == key_cost_q) && (rd_data.boat_left == key_boat_q);
	assign scan_last = (idx_q == count_q);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	assign stat.count = count_q;

	// Drive the entry store ports
	always_comb begin
		mem_req                   = '0;
		mem_req.wr_addr           = count_q[ADDR_W-1:0];
		mem_req.wr_data.cost      = narrow_cost(req.entry_cost);
		mem_req.wr_data.boat_left = req.entry_boat_left;
		mem_req.wr_data.handle    = req.entry_handle;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_PUSH: begin
							mem_req.wr_en = !full;
						end
						REQ_POP: begin
							mem_req.rd_en   = !empty;
							mem_req.rd_addr = cnt_dec[ADDR_W-1:0];
						end
						REQ_SEARCH: begin
							mem_req.rd_en   = !empty;
							mem_req.rd_addr = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				mem_req.rd_en   = !match && !scan_last;
				mem_req.rd_addr = idx_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_PUSH: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_FIN;
							end
							REQ_POP: begin
								if (!empty) begin
									count_q <= cnt_dec;
									state_q <= ST_READ;
								end else begin
									state_q <= ST_FIN;
								end
							end
							REQ_SEARCH: begin
								state_q <= empty ? ST_FIN : ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					if (match || scan_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Build the pending result and walk the search index
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q.status    <= (req.req_type == REQ_PUSH && full) ? STAT_OVERFLOW :
					                   (req.req_type == REQ_POP && empty) ? STAT_UNDERFLOW :
					                   STAT_OK;
					res_q.found     <= 1'b0;
					res_q.cost      <= '0;
					res_q.boat_left <= 1'b0;
					res_q.handle    <= '0;
					idx_q           <= CNT_W'(1);
					key_cost_q      <= narrow_cost(req.entry_cost);
					key_boat_q      <= req.entry_boat_left;
				end
			end
			ST_READ: begin
				res_q.cost      <= widen_cost(rd_data.cost);
				res_q.boat_left <= rd_data.boat_left;
				res_q.handle    <= rd_data.handle;
			end
			ST_SCAN: begin
				if (match) begin
					res_q.found <= 1'b1;
				end
				idx_q <= idx_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Hold the response register until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q       <= res_q;
			out_fill_q  <= FILL_W'(count_q);
			out_empty_q <= empty;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.found         = out_q.found;
	assign rsp.out_cost      = out_q.cost;
	assign rsp.out_boat_left = out_q.boat_left;
	assign rsp.out_handle    = out_q.handle;
	assign rsp.is_empty      = out_empty_q;
	assign rsp.fill_count    = out_fill_q;

endmodule

// ===== rtl/core/lifo_stack_with_search_top.sv =====
// LIFO stack with search, top level. Push, pop on an empty stack and unused codes
// go from idle to the finish state; other pops pass through a read state first;
// search walks the entry store (one entry store read per entry, stopping at the
// first match) before the finish state. A new request is taken as soon as the
// previous one is in the response register, and not before.
// Reset clears the fill count and handshake state; the entry store is not cleared.
`timescale 1ns / 1ps

module lifo_stack_with_search_top (
	input  logic      clk,
	input  logic      arst_n,
	lss_req_if.sink   req,
	lss_rsp_if.source rsp
);
	import lss_pkg::*;

	mem_req_t  mem_req;
	entry_t    rd_data;
	seq_stat_t stat;

	lss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rd_data (rd_data),
		.stat    (stat)
	);

	lss_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// Fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// Store writes only on an accepted push
	a_write_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (req.valid && req.ready && req.req_type == REQ_PUSH))
		else $error("store write without push");

	// A write bumps the fill count by one
	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |=> (stat.count == CNT_W'($past(stat.count) + CNT_W'(1))))
		else $error("fill count not advanced on push");

	// Never read and write the store together
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("store read and write in one cycle");

	// Empty flag agrees with the fill count on every response
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (rsp.fill_count == '0)))
		else $error("empty flag disagrees with fill count");

endmodule

// ===== sim/lifo_stack_with_search_top_test.sv =====
// Self-checking testbench for lifo_stack_with_search_top: push, pop and search traffic
// on valid/ready channels, with each response checked against a stack predictor.
// Depends on lss_pkg, lss_if (lss_req_if, lss_rsp_if) and the RTL top level.
`timescale 1ns / 1ps

module lifo_stack_with_search_top_test;
	import lss_pkg::*;

	// Request code the block ignores; it still answers with one response
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1000;
	localparam int NUM_PHASES   = 4;
	// A search walks at most DEPTH entries, plus the pipeline
	localparam int DRAIN_CYCLES = DEPTH + 8;
	// Worst case: every item a full search with long gaps and stalls, several times over
	localparam int LIMIT_NS     = 5_000_000;

	typedef struct packed {
		logic [REQ_W-1:0]     req_type;
		logic [IN_COST_W-1:0] cost;
		logic                 boat_left;
		logic [HANDLE_W-1:0]  handle;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 found;
		logic [IN_COST_W-1:0] cost;
		logic                 boat_left;
		logic [HANDLE_W-1:0]  handle;
		logic                 is_empty;
		logic [FILL_W-1:0]    fill_count;
	} outcome_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	// Stack predictor and queue of outstanding expected responses
	class stack_scoreboard;
		entry_t      stack_mem [DEPTH];
		int unsigned depth_used;
		outcome_t    pending [$];
		int unsigned failures;

		function new();
			depth_used = 0;
			failures   = 0;
		endfunction

		// Apply one accepted request to the stack copy and queue its response
		function void note_request(request_t r);
			outcome_t              o;
			entry_t                e;
			logic [COST_WIDTH-1:0] key;
			int unsigned           i;
			o   = '0;
			key = r.cost[COST_WIDTH-1:0];
			case (r.req_type)
				REQ_PUSH: begin
					if (depth_used < DEPTH) begin
						e.cost      = key;
						e.boat_left = r.boat_left;
						e.handle    = r.handle;
						stack_mem[depth_used] = e;
						depth_used++;
					end else begin
						o.status = STAT_OVERFLOW;
					end
				end
				REQ_POP: begin
					if (depth_used > 0) begin
						depth_used--;
						e           = stack_mem[depth_used];
						o.cost      = IN_COST_W'(e.cost);
						o.boat_left = e.boat_left;
						o.handle    = e.handle;
					end else begin
						o.status = STAT_UNDERFLOW;
					end
				end
				REQ_SEARCH: begin
					for (i = 0; i < depth_used; i++) begin
						if (stack_mem[i].cost == key && stack_mem[i].boat_left == r.boat_left) begin
							o.found = 1'b1;
							break;
						end
					end
				end
				default: ;
			endcase
			o.is_empty   = (depth_used == 0);
			o.fill_count = FILL_W'(depth_used);
			pending.push_back(o);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				failures++;
			end
		endfunction

		// Match one response against the oldest expectation
		function void check_result(outcome_t got);
			outcome_t want;
			if (pending.size() == 0) begin
				$display("%0t: response with none outstanding, expected none, actual %p", $time, got);
				failures++;
				return;
			end
			want = pending.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("found", 32'(want.found), 32'(got.found));
			compare_field("out_cost", 32'(want.cost), 32'(got.cost));
			compare_field("out_boat_left", 32'(want.boat_left), 32'(got.boat_left));
			compare_field("out_handle", 32'(want.handle), 32'(got.handle));
			compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
			compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
		endfunction

		// Any entry currently on the stack; only called when it holds something
		function entry_t pick_stored();
			return stack_mem[$urandom_range(0, depth_used - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lss_req_if req_ch ();
	lss_rsp_if rsp_ch ();

	lifo_stack_with_search_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stack_scoreboard sb = new();
	int unsigned     idle_pct  = 0;
	int unsigned     stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Offer one request, with random idle cycles ahead of it, and hold until accepted
	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= r.req_type;
		req_ch.entry_cost      <= r.cost;
		req_ch.entry_boat_left <= r.boat_left;
		req_ch.entry_handle    <= r.handle;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	function automatic request_t make_request(logic [REQ_W-1:0] kind, logic [IN_COST_W-1:0] cost,
			logic boat, logic [HANDLE_W-1:0] handle);
		request_t r;
		r.req_type  = kind;
		r.cost      = cost;
		r.boat_left = boat;
		r.handle    = handle;
		return r;
	endfunction

	// Random request biased by traffic mode; searches often aim at stored entries
	function automatic request_t random_request(traffic_mode_t mode);
		request_t    r;
		entry_t      e;
		int unsigned roll;
		int unsigned push_lim;
		int unsigned pop_lim;
		int unsigned search_lim;
		case (mode)
			MODE_FILL: begin
				push_lim = 72; pop_lim = 84; search_lim = 97;
			end
			MODE_DRAIN: begin
				push_lim = 12; pop_lim = 80; search_lim = 97;
			end
			default: begin
				push_lim = 35; pop_lim = 65; search_lim = 95;
			end
		endcase
		r.cost      = ($urandom_range(0, 99) < 50) ? IN_COST_W'($urandom_range(0, 7))
		                                          : IN_COST_W'($urandom_range(0, 65535));
		r.boat_left = 1'($urandom_range(0, 1));
		r.handle    = HANDLE_W'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < push_lim)
			r.req_type = REQ_PUSH;
		else if (roll < pop_lim)
			r.req_type = REQ_POP;
		else if (roll < search_lim)
			r.req_type = REQ_SEARCH;
		else
			r.req_type = REQ_UNUSED;
		if (r.req_type == REQ_SEARCH && sb.depth_used > 0 && $urandom_range(0, 99) < 60) begin
			e           = sb.pick_stored();
			r.cost      = IN_COST_W'(e.cost);
			r.boat_left = ($urandom_range(0, 3) == 0) ? ~e.boat_left : e.boat_left;
		end
		return r;
	endfunction

	// Response side: check each transaction, then pick ready for the next edge
	initial begin
		outcome_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.status     = rsp_ch.status;
				got.found      = rsp_ch.found;
				got.cost       = rsp_ch.out_cost;
				got.boat_left  = rsp_ch.out_boat_left;
				got.handle     = rsp_ch.out_handle;
				got.is_empty   = rsp_ch.is_empty;
				got.fill_count = rsp_ch.fill_count;
				sb.check_result(got);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Stimulus: reset, directed cases, then random traffic over the idle and stall phases
	initial begin
		request_t      r;
		traffic_mode_t mode;
		int unsigned   seg;
		int unsigned   k;
		int unsigned   sent;
		int            ph;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.req_type        <= REQ_PUSH;
		req_ch.entry_cost      <= '0;
		req_ch.entry_boat_left <= 1'b0;
		req_ch.entry_handle    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: underflow, search miss, ignored code
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_SEARCH, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF));
		// Field extremes, hits at top and bottom, boat-side mismatch
		send_request(make_request(REQ_PUSH, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_PUSH, 16'hFFFF, 1'b1, 16'hFFFF));
		send_request(make_request(REQ_SEARCH, 16'hFFFF, 1'b1, 16'h1234));
		send_request(make_request(REQ_SEARCH, 16'hFFFF, 1'b0, 16'h0000));
		send_request(make_request(REQ_SEARCH, 16'h0000, 1'b0, 16'hFFFF));
		send_request(make_request(REQ_SEARCH, 16'h0000, 1'b1, 16'h0000));
		send_request(make_request(REQ_UNUSED, 16'h5A5A, 1'b1, 16'hA5A5));
		send_request(make_request(REQ_PUSH, 16'h1234, 1'b0, 16'hABCD));
		send_request(make_request(REQ_SEARCH, 16'h1234, 1'b0, 16'h0000));
		// Drain past empty
		send_request(make_request(REQ_POP, 16'hFFFF, 1'b1, 16'hFFFF));
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_SEARCH, 16'h1234, 1'b0, 16'h0000));
		send_request(make_request(REQ_PUSH, 16'hAAAA, 1'b1, 16'h5555));
		send_request(make_request(REQ_PUSH, 16'h5555, 1'b0, 16'hAAAA));
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));
		send_request(make_request(REQ_POP, 16'h0000, 1'b0, 16'h0000));

		// Random segments of fill, drain and mixed traffic under each idle and stall pattern
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / NUM_PHASES) begin
				mode = traffic_mode_t'($urandom_range(0, 2));
				seg  = $urandom_range(30, 150);
				for (k = 0; k < seg && sent < RANDOM_ITEMS / NUM_PHASES; k++) begin
					r = random_request(mode);
					send_request(r);
					if (r.req_type != REQ_UNUSED)
						sent++;
				end
			end
		end
		req_ch.valid <= 1'b0;

		// Wait out outstanding responses, then watch for strays
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
